>>> src/crczt_pkg.sv
// shared types, codes and the crc-32c byte update for the trimmed block checksum
package crczt_pkg;

	localparam int BS_W       = 17;
	localparam int OFF_W      = 16;
	localparam int LEN_W      = 32;
	localparam int CRC_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic FUNC_HDR  = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	localparam logic [KIND_W-1:0] KIND_SUM    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OVF    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NODATA = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_OVF = 2'd1;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [BS_W-1:0]  BS_RESET = 17'd4096;

	typedef struct packed {
		logic start;
		logic clear;
	} mod_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [OFF_W-1:0] rem;
	} mod_stat_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> src/crczt_mod.sv
// bit-serial remainder unit that reduces a header offset modulo the block size
module crczt_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [crczt_pkg::OFF_W-1:0]    dividend,
	input  logic [crczt_pkg::BS_W-1:0]     divisor,
	input  crczt_pkg::mod_ctrl_t           ctrl,
	output crczt_pkg::mod_stat_t           stat
);

	logic                        busy_q;
	logic                        done_q;
	logic [3:0]                  cnt_q;
	logic [crczt_pkg::OFF_W-1:0] quo_q;
	logic [crczt_pkg::OFF_W-1:0] rem_q;
	logic [crczt_pkg::BS_W-1:0]  trial;
	logic [crczt_pkg::BS_W-1:0]  rem_n;

	assign trial = {rem_q, quo_q[crczt_pkg::OFF_W-1]};
	assign rem_n = (trial >= divisor) ? (trial - divisor) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 4'd15;
		end else if (busy_q) begin
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end else if (ctrl.clear) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[crczt_pkg::OFF_W-2:0], 1'b0};
			rem_q <= rem_n[crczt_pkg::OFF_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

>>> src/block_crc32c_zero_trim.sv
// top level: per-block crc-32c of a byte range with trailing zero bytes trimmed
// a request is registered in the input stage, and its result in the output register
// throughput: one request per cycle while the output is not stalled; a header whose offset
//   is not below the block size holds the input while the bit-serial remainder unit reduces it
// reset: asynchronous active low, clears the range state, empties both stages and
//   restores block size 4096 (capped at the block limit) and overflow reporting
module block_crc32c_zero_trim #(
	parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crczt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crczt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [crczt_pkg::OFF_W-1:0]         offset_in_block,
	input  logic [crczt_pkg::LEN_W-1:0]         range_length,
	input  logic [crczt_pkg::LEN_W-1:0]         available_bytes,
	input  logic [crczt_pkg::BYTE_W-1:0]        data_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [crczt_pkg::KIND_W-1:0]        kind,
	output logic [crczt_pkg::CRC_W-1:0]         checksum,
	output logic                                last
);

	// configuration
	logic [crczt_pkg::BS_W-1:0]   bs_q;
	logic                         ign_q;
	logic [crczt_pkg::BS_W-1:0]   bs_clamped;

	// range state
	logic [crczt_pkg::CRC_W-1:0]  run_q;
	logic [crczt_pkg::CRC_W-1:0]  comm_q;
	logic [crczt_pkg::BS_W-1:0]   piece_q;
	logic [crczt_pkg::LEN_W-1:0]  range_q;
	logic                         active_q;

	// input stage
	logic                         valid_s1;
	logic                         func_s1;
	logic [crczt_pkg::OFF_W-1:0]  off_s1;
	logic [crczt_pkg::LEN_W-1:0]  len_s1;
	logic [crczt_pkg::LEN_W-1:0]  avail_s1;
	logic [crczt_pkg::BYTE_W-1:0] byte_s1;

	// output register
	logic                         out_valid_q;
	logic [crczt_pkg::KIND_W-1:0] kind_q;
	logic [crczt_pkg::CRC_W-1:0]  checksum_q;
	logic                         last_q;

	logic                         out_free;
	logic                         need_mod;
	logic                         consume;
	logic                         load_s1;
	crczt_pkg::mod_ctrl_t         mod_ctrl;
	crczt_pkg::mod_stat_t         mod_stat;

	// next-state and result
	logic                         res_valid;
	logic [crczt_pkg::KIND_W-1:0] res_kind;
	logic [crczt_pkg::CRC_W-1:0]  res_sum;
	logic                         res_last;
	logic [crczt_pkg::CRC_W-1:0]  run_n;
	logic [crczt_pkg::CRC_W-1:0]  comm_n;
	logic [crczt_pkg::BS_W-1:0]   piece_n;
	logic [crczt_pkg::LEN_W-1:0]  range_n;
	logic                         active_n;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			bs_clamped = crczt_pkg::BS_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_BLOCK_BYTES)) begin
			bs_clamped = crczt_pkg::BS_W'(MAX_BLOCK_BYTES);
		end else begin
			bs_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q  <= (MAX_BLOCK_BYTES < 32'(crczt_pkg::BS_RESET)) ?
				crczt_pkg::BS_W'(MAX_BLOCK_BYTES) : crczt_pkg::BS_RESET;
			ign_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crczt_pkg::CFG_BLOCK_SIZE: bs_q <= bs_clamped;
				crczt_pkg::CFG_IGNORE_OVF: ign_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake between stages
	assign out_free = !out_valid_q || !out_stall;
	assign need_mod = valid_s1 && (func_s1 == crczt_pkg::FUNC_HDR) &&
		({1'b0, off_s1} >= bs_q);
	assign consume  = valid_s1 && out_free && (!need_mod || mod_stat.done);
	assign in_stall = valid_s1 && !consume;
	assign load_s1  = in_valid && !in_stall;

	assign mod_ctrl.start = need_mod && !mod_stat.busy && !mod_stat.done;
	assign mod_ctrl.clear = consume && need_mod;

	crczt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.dividend (off_s1),
		.divisor  (bs_q),
		.ctrl     (mod_ctrl),
		.stat     (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1  <= func;
			off_s1   <= offset_in_block;
			len_s1   <= range_length;
			avail_s1 <= available_bytes;
			byte_s1  <= data_byte;
		end
	end

	// one item of work
	always_comb begin
		logic [crczt_pkg::OFF_W-1:0] off_r;
		logic [crczt_pkg::BS_W-1:0]  first_len;
		logic [crczt_pkg::LEN_W-1:0] len_c;
		logic [crczt_pkg::CRC_W-1:0] crc_n;
		logic [crczt_pkg::BS_W-1:0]  piece_dec;
		logic [crczt_pkg::LEN_W-1:0] range_dec;

		res_valid = 1'b0;
		res_kind  = crczt_pkg::KIND_SUM;
		res_sum   = '0;
		res_last  = 1'b1;
		run_n     = run_q;
		comm_n    = comm_q;
		piece_n   = piece_q;
		range_n   = range_q;
		active_n  = active_q;

		off_r     = need_mod ? mod_stat.rem : off_s1;
		first_len = (off_r == '0) ? bs_q : (bs_q - {1'b0, off_r});
		len_c     = (avail_s1 < len_s1) ? avail_s1 : len_s1;
		crc_n     = crczt_pkg::crc_byte(run_q, byte_s1);
		piece_dec = piece_q - crczt_pkg::BS_W'(1);
		range_dec = range_q - crczt_pkg::LEN_W'(1);

		if (func_s1 == crczt_pkg::FUNC_HDR) begin
			run_n    = crczt_pkg::CRC_INIT;
			comm_n   = '0;
			piece_n  = '0;
			range_n  = '0;
			active_n = 1'b0;
			if (avail_s1 == '0) begin
				res_valid = 1'b1;
				res_kind  = ign_q ? crczt_pkg::KIND_NODATA : crczt_pkg::KIND_OVF;
			end else if ((avail_s1 < len_s1) && !ign_q) begin
				res_valid = 1'b1;
				res_kind  = crczt_pkg::KIND_OVF;
			end else if (len_c == '0) begin
				res_valid = 1'b1;
				res_kind  = crczt_pkg::KIND_NODATA;
			end else begin
				active_n = 1'b1;
				range_n  = len_c;
				piece_n  = (32'(first_len) < len_c) ? first_len : len_c[crczt_pkg::BS_W-1:0];
			end
		end else if (active_q) begin
			run_n   = crc_n;
			comm_n  = (byte_s1 != '0) ? ~crc_n : comm_q;
			piece_n = piece_dec;
			range_n = range_dec;
			if (piece_dec == '0) begin
				res_valid = 1'b1;
				res_kind  = crczt_pkg::KIND_SUM;
				res_sum   = comm_n;
				res_last  = (range_dec == '0);
				run_n     = crczt_pkg::CRC_INIT;
				comm_n    = '0;
				if (range_dec == '0) begin
					active_n = 1'b0;
				end else begin
					piece_n = (32'(bs_q) < range_dec) ? bs_q :
						range_dec[crczt_pkg::BS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= crczt_pkg::CRC_INIT;
			comm_q   <= '0;
			piece_q  <= '0;
			range_q  <= '0;
			active_q <= 1'b0;
		end else if (consume) begin
			run_q    <= run_n;
			comm_q   <= comm_n;
			piece_q  <= piece_n;
			range_q  <= range_n;
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res_valid) begin
			kind_q     <= res_kind;
			checksum_q <= res_sum;
			last_q     <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign checksum  = checksum_q;
	assign last      = last_q;

endmodule

>>> src/crczt_chk.sv
// port-level checks on the result channel, bound to the top level
module crczt_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [crczt_pkg::KIND_W-1:0]   kind,
	input logic [crczt_pkg::CRC_W-1:0]    checksum,
	input logic                           last
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(checksum) &&
		$stable(last))
		else $error("stalled result changed");

	// error and no-data results close the range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != crczt_pkg::KIND_SUM) |-> last)
		else $error("non-checksum result without last");

	// error and no-data results carry no checksum
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != crczt_pkg::KIND_SUM) |-> (checksum == '0))
		else $error("non-checksum result with checksum");

	// only defined result kinds leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == crczt_pkg::KIND_SUM) || (kind == crczt_pkg::KIND_OVF) ||
		(kind == crczt_pkg::KIND_NODATA))
		else $error("undefined result kind");

endmodule

bind block_crc32c_zero_trim crczt_chk u_crczt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.checksum  (checksum),
	.last      (last)
);

>>> dv/block_crc32c_zero_trim_tb.sv
// testbench for the per-block trimmed crc-32c unit: directed and random ranges, self-checking
`timescale 1ns / 100ps

module block_crc32c_zero_trim_tb;

	localparam int unsigned BLOCK_LIMIT = 65536;
	localparam int ITEM_TARGET = 1000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic                             func;
		logic [crczt_pkg::OFF_W-1:0]      off;
		logic [crczt_pkg::LEN_W-1:0]      len;
		logic [crczt_pkg::LEN_W-1:0]      avail;
		logic [crczt_pkg::BYTE_W-1:0]     dbyte;
	} range_req_t;

	typedef struct packed {
		logic [crczt_pkg::KIND_W-1:0] kind;
		logic [crczt_pkg::CRC_W-1:0]  sum;
		logic                         last;
	} piece_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [crczt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [crczt_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             in_valid;
	logic                             in_stall;
	logic                             func;
	logic [crczt_pkg::OFF_W-1:0]      offset_in_block;
	logic [crczt_pkg::LEN_W-1:0]      range_length;
	logic [crczt_pkg::LEN_W-1:0]      available_bytes;
	logic [crczt_pkg::BYTE_W-1:0]     data_byte;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [crczt_pkg::KIND_W-1:0]     kind;
	logic [crczt_pkg::CRC_W-1:0]      checksum;
	logic                             last;

	// predictor state and register shadows
	logic [crczt_pkg::BS_W-1:0]  blk_size;
	logic                        trunc_mode;
	logic [crczt_pkg::CRC_W-1:0] crc_run;
	logic [crczt_pkg::CRC_W-1:0] crc_kept;
	logic [31:0]                 piece_left;
	logic [31:0]                 range_left;
	logic                        range_open;

	piece_result_t sums_due[$];
	piece_result_t due;

	int  errors = 0;
	int  items_sent = 0;
	int  hdr_cnt = 0;
	int  data_cnt = 0;
	int  sums_checked = 0;
	int  cfg_cnt = 0;
	bit  gaps_on = 1'b1;
	logic stalls_on;
	int  hold_asks;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  burst_left = 0;

	block_crc32c_zero_trim #(.MAX_BLOCK_BYTES(BLOCK_LIMIT)) uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("block_crc32c_zero_trim_tb NOT OK");
		$finish;
	end

	function automatic logic [crczt_pkg::CRC_W-1:0] crc32c_step(
		input logic [crczt_pkg::CRC_W-1:0] crc, input logic [crczt_pkg::BYTE_W-1:0] d);
		logic [crczt_pkg::CRC_W-1:0] c;
		c = crc;
		for (int i = 0; i < crczt_pkg::BYTE_W; i++) begin
			c = {1'b0, c[crczt_pkg::CRC_W-1:1]} ^ ((c[0] ^ d[i]) ? crczt_pkg::CRC_POLY : '0);
		end
		return c;
	endfunction

	function automatic logic [31:0] clamped_block();
		if (blk_size == '0)
			return 32'd1;
		if (blk_size > BLOCK_LIMIT)
			return BLOCK_LIMIT;
		return 32'(blk_size);
	endfunction

	function automatic void expect_result(input logic [crczt_pkg::KIND_W-1:0] k,
		input logic [crczt_pkg::CRC_W-1:0] s, input logic l);
		piece_result_t r;
		r.kind = k;
		r.sum = s;
		r.last = l;
		sums_due.push_back(r);
	endfunction

	function automatic void predict_piece_sums(input range_req_t r);
		logic [31:0] bs;
		logic [31:0] off;
		logic [31:0] len;
		bs = clamped_block();
		if (r.func == crczt_pkg::FUNC_HDR) begin
			off = 32'(r.off) % bs;
			len = r.len;
			range_open = 1'b0;
			piece_left = '0;
			range_left = '0;
			crc_run = crczt_pkg::CRC_INIT;
			crc_kept = '0;
			if (r.avail == '0) begin
				expect_result(trunc_mode ? crczt_pkg::KIND_NODATA : crczt_pkg::KIND_OVF,
					'0, 1'b1);
				return;
			end
			if (r.avail < len) begin
				if (!trunc_mode) begin
					expect_result(crczt_pkg::KIND_OVF, '0, 1'b1);
					return;
				end
				len = r.avail;
			end
			if (len == '0) begin
				expect_result(crczt_pkg::KIND_NODATA, '0, 1'b1);
				return;
			end
			range_open = 1'b1;
			range_left = len;
			piece_left = (off != '0) ? bs - off : bs;
			if (piece_left > len)
				piece_left = len;
		end else if (range_open) begin
			crc_run = crc32c_step(crc_run, r.dbyte);
			if (r.dbyte != '0)
				crc_kept = ~crc_run;
			piece_left--;
			range_left--;
			if (piece_left == '0) begin
				expect_result(crczt_pkg::KIND_SUM, crc_kept, range_left == '0);
				crc_run = crczt_pkg::CRC_INIT;
				crc_kept = '0;
				if (range_left == '0)
					range_open = 1'b0;
				else
					piece_left = (bs < range_left) ? bs : range_left;
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (sums_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d sum %h last %0d",
					$time, kind, checksum, last);
			end else begin
				due = sums_due.pop_front();
				check_field("kind", 32'(due.kind), 32'(kind));
				check_field("checksum", due.sum, checksum);
				check_field("last", 32'(due.last), 32'(last));
				sums_checked++;
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_item(input range_req_t r);
		logic counted;
		counted = (r.func == crczt_pkg::FUNC_HDR) || range_open;
		func <= r.func;
		offset_in_block <= r.off;
		range_length <= r.len;
		available_bytes <= r.avail;
		data_byte <= r.dbyte;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_piece_sums(r);
		if (counted)
			items_sent++;
		if (r.func == crczt_pkg::FUNC_HDR)
			hdr_cnt++;
		else
			data_cnt++;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_header(input logic [crczt_pkg::OFF_W-1:0] off,
		input logic [crczt_pkg::LEN_W-1:0] len, input logic [crczt_pkg::LEN_W-1:0] avail);
		range_req_t r;
		r.func = crczt_pkg::FUNC_HDR;
		r.off = off;
		r.len = len;
		r.avail = avail;
		r.dbyte = 8'($urandom);
		push_item(r);
	endtask

	task automatic send_data(input logic [crczt_pkg::BYTE_W-1:0] b);
		range_req_t r;
		r.func = crczt_pkg::FUNC_DATA;
		r.off = 16'($urandom);
		r.len = $urandom;
		r.avail = $urandom;
		r.dbyte = b;
		push_item(r);
	endtask

	function automatic logic [crczt_pkg::BYTE_W-1:0] rand_data();
		return ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom);
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [crczt_pkg::BS_W-1:0] bs, input logic ovf_trunc);
		wait_idle();
		cfg_index <= crczt_pkg::CFG_BLOCK_SIZE;
		cfg_data <= crczt_pkg::CFG_DATA_W'(bs);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		blk_size = bs;
		cfg_index <= crczt_pkg::CFG_IGNORE_OVF;
		cfg_data <= crczt_pkg::CFG_DATA_W'(ovf_trunc);
		do @(posedge clk); while (!cfg_ready);
		trunc_mode = ovf_trunc;
		cfg_valid <= 1'b0;
		cfg_cnt++;
	endtask

	task automatic test_open_cases();
		send_data(8'hFF);
		send_header(16'd0, 32'd0, 32'd0);
		send_header(16'd3, 32'd10, 32'd5);
		send_header(16'd0, 32'd0, 32'd7);
		send_header(16'd4094, 32'd4, 32'hFFFF_FFFF);
		send_data(8'h80);
		send_data(8'h01);
		send_data(8'h00);
		send_data(8'h00);
		// offset above the block size, then dropped by a new header
		send_header(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_data(8'h7F);
		send_data(8'hFE);
		send_header(16'd0, 32'd1, 32'd1);
		send_data(8'h00);
	endtask

	task automatic test_config_extremes();
		set_config(17'd1, 1'b1);
		send_header(16'd0, 32'd0, 32'd0);
		send_header(16'd0, 32'd3, 32'd2);
		send_data(8'h01);
		send_data(8'h00);
		set_config(17'd0, 1'b1);
		send_header(16'd5, 32'd1, 32'd1);
		send_data(8'hA5);
		set_config(17'h1FFFF, 1'b0);
		send_header(16'hFFFF, 32'd3, 32'd3);
		send_data(8'h55);
		send_data(8'hAA);
		send_data(8'h00);
	endtask

	task automatic test_mid_range_block_size();
		set_config(17'd4, 1'b0);
		send_header(16'd0, 32'd10, 32'd10);
		repeat (5) send_data(rand_data());
		set_config(17'd2, 1'b0);
		repeat (5) send_data(rand_data());
	endtask

	task automatic test_backpressure();
		set_config(17'd3, 1'b0);
		gaps_on = 1'b0;
		hold_asks <= hold_asks + 1;
		@(posedge clk);
		send_header(16'd0, 32'd60, 32'd60);
		repeat (60) send_data(rand_data());
		// sender holds until everything has drained
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		gaps_on = 1'b1;
	endtask

	task automatic pick_random_config();
		logic [crczt_pkg::BS_W-1:0] bs;
		case ($urandom_range(0, 11))
			0:       bs = 17'd1;
			1:       bs = 17'd2;
			2, 3, 4: bs = crczt_pkg::BS_W'($urandom_range(3, 8));
			5, 6:    bs = crczt_pkg::BS_W'($urandom_range(9, 40));
			7:       bs = crczt_pkg::BS_W'($urandom_range(41, 4096));
			8:       bs = 17'd65536;
			9:       bs = 17'd0;
			10:      bs = crczt_pkg::BS_W'($urandom_range(65537, 131071));
			default: bs = crczt_pkg::BS_W'($urandom_range(1, 16));
		endcase
		set_config(bs, 1'($urandom_range(0, 1)));
	endtask

	task automatic random_range();
		logic [31:0] eff;
		logic [31:0] off;
		logic [31:0] len;
		logic [31:0] avail;
		int sel;
		int n;
		eff = clamped_block();
		sel = $urandom_range(0, 99);
		off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, eff - 1);
		if (sel < 8 && !range_open) begin
			// stray bytes with nothing open
			repeat ($urandom_range(1, 3)) send_data(8'($urandom));
		end else if (sel < 18) begin
			// huge or random lengths, left unfinished
			len = $urandom;
			avail = ($urandom_range(0, 1) == 0) ? $urandom : len;
			send_header(16'(off), len, avail);
			if (range_open) begin
				n = $urandom_range(0, 12);
				if (n >= range_left)
					n = range_left - 1;
				repeat (n) send_data(rand_data());
			end
		end else begin
			case ($urandom_range(0, 19))
				0:       len = 0;
				1, 2:    len = $urandom_range(41, 200);
				default: len = $urandom_range(1, 40);
			endcase
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					avail = $urandom;
					if (avail < len)
						avail = len;
				end
				3, 4, 5: avail = (len == 0) ? 32'd0 : $urandom_range(1, len);
				6, 7:    avail = 0;
				default: avail = len + $urandom_range(0, 100);
			endcase
			send_header(16'(off), len, avail);
			if (range_open)
				repeat (range_left) send_data(rand_data());
		end
	endtask

	task automatic test_random_traffic();
		int groups;
		logic quiet;
		groups = 0;
		while (items_sent < ITEM_TARGET) begin
			quiet = items_sent > ITEM_TARGET - 150;
			if (quiet) begin
				gaps_on = 1'b0;
				stalls_on <= 1'b0;
			end else if (groups % 8 == 0) begin
				gaps_on = $urandom_range(0, 3) != 0;
				stalls_on <= $urandom_range(0, 3) != 0;
				pick_random_config();
			end
			random_range();
			groups++;
		end
	endtask

	initial begin
		int guard;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= crczt_pkg::CFG_BLOCK_SIZE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		func <= crczt_pkg::FUNC_HDR;
		offset_in_block <= '0;
		range_length <= '0;
		available_bytes <= '0;
		data_byte <= '0;
		stalls_on <= 1'b1;
		hold_asks <= 0;
		blk_size = crczt_pkg::BS_RESET;
		trunc_mode = 1'b0;
		range_open = 1'b0;
		piece_left = '0;
		range_left = '0;
		crc_run = crczt_pkg::CRC_INIT;
		crc_kept = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_open_cases();
		test_config_extremes();
		test_mid_range_block_size();
		test_backpressure();
		test_random_traffic();
		in_valid <= 1'b0;
		stalls_on <= 1'b0;
		guard = 0;
		while (sums_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sums_due.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, sums_due.size());
		end
		$display("covered %0d headers and %0d data bytes over %0d register settings",
			hdr_cnt, data_cnt, cfg_cnt);
		$display("%0d results compared, %0d mismatches", sums_checked, errors);
		if (errors == 0)
			$display("block_crc32c_zero_trim_tb OK");
		else
			$display("block_crc32c_zero_trim_tb NOT OK");
		$finish;
	end

endmodule

>>> block_crc32c_zero_trim.f
src/crczt_pkg.sv
src/crczt_mod.sv
src/block_crc32c_zero_trim.sv
src/crczt_chk.sv
dv/block_crc32c_zero_trim_tb.sv
